>>> sv/cba_pkg.sv
// Shared types, codes and constants of the chained bump allocator.
package cba_pkg;

	localparam int OP_W    = 2;
	localparam int SIZE_W  = 24;
	localparam int ALIGN_W = 17;
	localparam int MBLK_W  = 4;
	localparam int OFF_W   = 25;
	localparam int TOT_W   = 29;
	localparam int IDX_W   = 4;
	localparam int CNT_W   = 5;
	localparam int BSZ_W   = 25;
	localparam int STAT_W  = 2;

	// block size used when the register holds zero, and the smallest block
	localparam logic [BSZ_W-1:0] DEFAULT_BLOCK  = BSZ_W'(64 * 1024);
	localparam logic [BSZ_W-1:0] SMALLEST_BLOCK = BSZ_W'(4 * 1024);

	// operation codes
	localparam logic [OP_W-1:0] OP_ALLOC    = 2'd0;
	localparam logic [OP_W-1:0] OP_RESET    = 2'd1;
	localparam logic [OP_W-1:0] OP_MARK     = 2'd2;
	localparam logic [OP_W-1:0] OP_ROLLBACK = 2'd3;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD_REQ  = 2'd1;
	localparam logic [STAT_W-1:0] ST_NO_BLOCK = 2'd2;
	localparam logic [STAT_W-1:0] ST_BAD_MARK = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [SIZE_W-1:0]  alloc_size;
		logic [ALIGN_W-1:0] alloc_align;
		logic [MBLK_W-1:0]  mark_block;
		logic [OFF_W-1:0]   mark_offset;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  block_index;
		logic [OFF_W-1:0]  offset;
		logic [TOT_W-1:0]  used_sum;
		logic [TOT_W-1:0]  cap_sum;
		logic [CNT_W-1:0]  blk_cnt;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_walk;
		logic walk_done;
	} sts_t;

endpackage

>>> sv/cba_ctrl.sv
// Controller state machine of the chained bump allocator.
module cba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	input  cba_pkg::sts_t sts,
	output cba_pkg::cmd_t cmd
);
	import cba_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic state_nxt;
	logic out_vld_q;
	logic out_free;

	// result slot can take a new item this cycle
	assign out_free = !out_vld_q || !rsp_stall;

	// sequence: take item, walk if rolling back, commit when the slot is free
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.is_walk && !sts.walk_done) begin
					cmd.step = 1'b1;
				end else if (out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// advance state and track the result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				out_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_vld_q;

endmodule

>>> sv/cba_dpath.sv
// Datapath of the chained bump allocator: block tables, totals and result register.
module cba_dpath #(
	parameter int MAX_BLOCKS = 16,
	parameter int MIN_ALIGN  = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cba_pkg::cmd_t              cmd,
	output cba_pkg::sts_t              sts,
	input  logic                       cfg_we,
	input  logic [cba_pkg::BSZ_W-1:0]  cfg_data,
	input  cba_pkg::req_t              req,
	output cba_pkg::rsp_t              rsp
);
	import cba_pkg::*;

	localparam int AW   = $clog2(MAX_BLOCKS);
	localparam int CW   = $clog2(MAX_BLOCKS + 1);
	localparam int CMPW = (CW > MBLK_W) ? CW : MBLK_W;
	localparam int IXW  = (AW > IDX_W) ? AW : IDX_W;
	localparam int CXW  = (CW > CNT_W) ? CW : CNT_W;

	// configuration and allocator state
	logic [BSZ_W-1:0] bsize_q;
	logic [CW-1:0]    live_q;
	logic [TOT_W-1:0] used_q;
	logic [TOT_W-1:0] ctot_q;
	logic             vld0_q;

	// block tables
	logic [OFF_W-1:0] cap_mem  [MAX_BLOCKS];
	logic [OFF_W-1:0] fill_mem [MAX_BLOCKS];
	logic [OFF_W-1:0] cap_rd_q;
	logic [OFF_W-1:0] fill_rd_q;
	logic             rd0_q;
	logic             fill_unset_q;
	logic [OFF_W-1:0] cap_rd;
	logic [OFF_W-1:0] fill_rd;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;

	// latched item
	logic [OP_W-1:0]    op_q;
	logic [SIZE_W-1:0]  size_q;
	logic [ALIGN_W-1:0] mask_q;
	logic               bad_q;
	logic [BSZ_W-1:0]   nsize_q;
	logic [CMPW-1:0]    mblk_q;
	logic [OFF_W-1:0]   moff_q;

	// roll back walk
	logic [AW-1:0]    idx_q;
	logic [TOT_W-1:0] uacc_q;
	logic [TOT_W-1:0] cacc_q;

	// request decode at load
	logic [BSZ_W-1:0]   eff_size;
	logic [ALIGN_W-1:0] align_eff;
	logic [ALIGN_W-1:0] align_m1;
	logic               bad_in;
	logic [BSZ_W-1:0]   grow;
	logic [BSZ_W-1:0]   nsize_in;

	// commit logic
	logic [CW-1:0]    cur_w;
	logic [AW-1:0]    cur_a;
	logic [AW-1:0]    live_a;
	logic [AW-1:0]    mblk_a;
	logic [OFF_W:0]   sum26;
	logic [OFF_W:0]   aligned;
	logic [OFF_W+1:0] fin;
	logic             fits;
	logic             full;
	logic             mblk_ok;
	logic [STAT_W-1:0] st_n;
	logic [IXW-1:0]   blk_n;
	logic [OFF_W-1:0] off_n;
	logic [TOT_W-1:0] used_n;
	logic [TOT_W-1:0] ctot_n;
	logic [CW-1:0]    live_n;
	logic [CXW-1:0]   live_x;
	logic             fill_we;
	logic             cap_we;
	logic [AW-1:0]    waddr;
	logic [OFF_W-1:0] fill_wdata;
	logic             vld0_clr;

	// resolve the configured block size
	always_comb begin
		if (bsize_q == '0) begin
			eff_size = DEFAULT_BLOCK;
		end else if (bsize_q < SMALLEST_BLOCK) begin
			eff_size = SMALLEST_BLOCK;
		end else begin
			eff_size = bsize_q;
		end
	end

	// raise alignment, check request, size a possible new block
	always_comb begin
		if (req.alloc_align < ALIGN_W'(MIN_ALIGN)) begin
			align_eff = ALIGN_W'(MIN_ALIGN);
		end else begin
			align_eff = req.alloc_align;
		end
		align_m1 = align_eff - 1'b1;
		bad_in   = (req.alloc_size == '0) || ((align_eff & align_m1) != '0);
		grow     = BSZ_W'(req.alloc_size) + BSZ_W'(align_eff);
		nsize_in = (grow > eff_size) ? grow : eff_size;
	end

	assign cur_w   = live_q - 1'b1;
	assign cur_a   = cur_w[AW-1:0];
	assign live_a  = live_q[AW-1:0];
	assign mblk_a  = mblk_q[AW-1:0];
	assign full    = (live_q >= CW'(MAX_BLOCKS));
	assign mblk_ok = (mblk_q < CMPW'(live_q));

	assign sts.is_walk   = (op_q == OP_ROLLBACK) && mblk_ok;
	assign sts.walk_done = (idx_q == mblk_a);

	// table read port: current block on load (block 0 for roll back), next entry while walking
	assign rd_en   = cmd.load || cmd.step;
	assign rd_addr = cmd.load ? ((req.op == OP_ROLLBACK) ? '0 : cur_a) : (idx_q + 1'b1);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			cap_rd_q     <= cap_mem[rd_addr];
			fill_rd_q    <= fill_mem[rd_addr];
			rd0_q        <= (rd_addr == '0);
			fill_unset_q <= (rd_addr == '0) && !vld0_q;
		end
	end

	// block 0 capacity is fixed at reset; its fill reads zero until written
	assign cap_rd  = rd0_q ? DEFAULT_BLOCK : cap_rd_q;
	assign fill_rd = fill_unset_q ? '0 : fill_rd_q;

	// bump arithmetic on the current block
	always_comb begin
		sum26   = (OFF_W + 1)'(fill_rd) + (OFF_W + 1)'(mask_q);
		aligned = sum26 & ~((OFF_W + 1)'(mask_q));
		fin     = (OFF_W + 2)'(aligned) + (OFF_W + 2)'(size_q);
		fits    = (fin <= (OFF_W + 2)'(cap_rd));
	end

	// next state and result of the item
	always_comb begin
		st_n       = ST_OK;
		blk_n      = IXW'(cur_a);
		off_n      = '0;
		used_n     = used_q;
		ctot_n     = ctot_q;
		live_n     = live_q;
		fill_we    = 1'b0;
		cap_we     = 1'b0;
		waddr      = cur_a;
		fill_wdata = fin[OFF_W-1:0];
		vld0_clr   = 1'b0;
		case (op_q)
			OP_ALLOC: begin
				if (bad_q) begin
					st_n = ST_BAD_REQ;
				end else if (fits) begin
					fill_we = 1'b1;
					used_n  = used_q + TOT_W'(size_q);
					off_n   = aligned[OFF_W-1:0];
				end else if (full) begin
					st_n = ST_NO_BLOCK;
				end else begin
					fill_we    = 1'b1;
					cap_we     = 1'b1;
					waddr      = live_a;
					fill_wdata = OFF_W'(size_q);
					live_n     = live_q + 1'b1;
					used_n     = used_q + TOT_W'(size_q);
					ctot_n     = ctot_q + TOT_W'(nsize_q);
					blk_n      = IXW'(live_a);
				end
			end
			OP_RESET: begin
				live_n   = CW'(1);
				used_n   = '0;
				ctot_n   = TOT_W'(DEFAULT_BLOCK);
				blk_n    = '0;
				vld0_clr = 1'b1;
			end
			OP_MARK: begin
				off_n = fill_rd;
			end
			OP_ROLLBACK: begin
				if (!mblk_ok) begin
					st_n = ST_BAD_MARK;
				end else begin
					fill_we    = 1'b1;
					waddr      = mblk_a;
					fill_wdata = moff_q;
					live_n     = CW'(mblk_q) + 1'b1;
					used_n     = uacc_q + TOT_W'(moff_q);
					ctot_n     = cacc_q + TOT_W'(cap_rd);
					blk_n      = IXW'(mblk_a);
					off_n      = moff_q;
				end
			end
			default: begin
				st_n = ST_OK;
			end
		endcase
		live_x = CXW'(live_n);
	end

	// write the block tables on commit
	always_ff @(posedge clk) begin
		if (cmd.commit && fill_we) begin
			fill_mem[waddr] <= fill_wdata;
		end
		if (cmd.commit && cap_we) begin
			cap_mem[waddr] <= nsize_q;
		end
	end

	// hold configuration and allocator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsize_q <= DEFAULT_BLOCK;
			live_q  <= CW'(1);
			used_q  <= '0;
			ctot_q  <= TOT_W'(DEFAULT_BLOCK);
			vld0_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				bsize_q <= cfg_data;
			end
			if (cmd.commit) begin
				live_q <= live_n;
				used_q <= used_n;
				ctot_q <= ctot_n;
				if (vld0_clr) begin
					vld0_q <= 1'b0;
				end else if (fill_we && (waddr == '0)) begin
					vld0_q <= 1'b1;
				end
			end
		end
	end

	// latch the item, run the walk, load the result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= req.op;
			size_q  <= req.alloc_size;
			mask_q  <= align_m1;
			bad_q   <= bad_in;
			nsize_q <= nsize_in;
			mblk_q  <= CMPW'(req.mark_block);
			moff_q  <= req.mark_offset;
			idx_q   <= '0;
			uacc_q  <= '0;
			cacc_q  <= '0;
		end else if (cmd.step) begin
			idx_q  <= idx_q + 1'b1;
			uacc_q <= uacc_q + TOT_W'(fill_rd);
			cacc_q <= cacc_q + TOT_W'(cap_rd);
		end
		if (cmd.commit) begin
			rsp.status      <= st_n;
			rsp.block_index <= blk_n[IDX_W-1:0];
			rsp.offset      <= off_n;
			rsp.used_sum    <= used_n;
			rsp.cap_sum     <= ctot_n;
			rsp.blk_cnt     <= live_x[CNT_W-1:0];
		end
	end

endmodule

>>> sv/chained_bump_allocator_core.sv
// Top level of the chained bump allocator: controller, datapath and checks.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------
//  req      | req_valid / req_stall  | req  (op, size, align, mark)
//  rsp      | rsp_valid / rsp_stall  | rsp  (status, block, offset, totals)
//  cfg      | cfg_valid / cfg_ready  | cfg_data (block size)
//
// Alloc, reset and mark read the current block entry from the block tables as the
// item is taken, then compute and write it back at commit. Roll back first walks
// the table read port from block 0 up to mark_block, summing the fill and capacity
// of each kept block, then commits. No clearing pass after reset; block 0
// is valid at once. A new item is taken while a result waits in the output
// register; a stalled result holds the commit of the next item.
module chained_bump_allocator_core #(
	parameter int MAX_BLOCKS = 16,
	parameter int MIN_ALIGN  = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  cba_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output cba_pkg::rsp_t             rsp,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [cba_pkg::BSZ_W-1:0] cfg_data
);
	import cba_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// always take register writes; the block size is sampled as an item is taken
	assign cfg_ready = 1'b1;

	cba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	cba_dpath #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.MIN_ALIGN  (MIN_ALIGN)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.req      (req),
		.rsp      (rsp)
	);

	// an accepted item blocks the next until its result commits
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("item accepted while previous item still in work");

	// a failed request reports no offset
	a_fail_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |-> (rsp.offset == '0))
		else $error("failed request carries nonzero offset");

	// a result appears only out of an item in work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result raised with no item in work");

endmodule
